/* sv/ita2e_pkg.sv */
// package: payload types, ita2 tables and the table lookup function
`default_nettype none

package ita2e_pkg;

  localparam int unsigned TabDepth = 32;
  localparam int unsigned CodeW    = 5;
  localparam int unsigned CharW    = 16;

  localparam logic [CodeW-1:0] SHIFT_LETTERS = 5'h1F;
  localparam logic [CodeW-1:0] SHIFT_FIGURES = 5'h1B;
  localparam logic [CharW-1:0] MAX_SEVEN_BIT = 16'h007F;
  localparam logic [CodeW-1:0] POS_CR        = 5'h02;
  localparam logic [CodeW-1:0] POS_LF        = 5'h08;
  localparam logic [CodeW-1:0] POS_SPACE     = 5'h04;

  // shift slots (27 and 31) never match
  localparam logic [TabDepth-1:0] SLOT_MASK = 32'h77FF_FFFF;

  typedef logic [7:0] tab_entry_t;
  typedef tab_entry_t tab_arr_t [TabDepth];

  localparam tab_arr_t LETTERS_TAB = '{
    8'h00, 8'h45, 8'h0D, 8'h41, 8'h20, 8'h53, 8'h49, 8'h55,
    8'h0A, 8'h44, 8'h52, 8'h4A, 8'h4E, 8'h46, 8'h43, 8'h4B,
    8'h54, 8'h5A, 8'h4C, 8'h57, 8'h48, 8'h59, 8'h50, 8'h51,
    8'h4F, 8'h42, 8'h47, 8'h00, 8'h4D, 8'h58, 8'h56, 8'h00
  };

  localparam tab_arr_t FIGURES_TAB = '{
    8'h00, 8'h33, 8'h0D, 8'h2D, 8'h20, 8'h27, 8'h38, 8'h37,
    8'h0A, 8'h05, 8'h34, 8'h07, 8'h2C, 8'h21, 8'h3A, 8'h28,
    8'h35, 8'h2B, 8'h29, 8'h32, 8'h24, 8'h36, 8'h30, 8'h31,
    8'h39, 8'h3F, 8'h26, 8'h00, 8'h2E, 8'h2F, 8'h3B, 8'h00
  };

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [CodeW-1:0] ita2_code;
    logic             last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic             hit;        // character has a code
    logic             direct;     // lf, cr or space: no shift in either mode
    logic             is_letter;  // found in the letters table
    logic [CodeW-1:0] pos;
  } lkup_t;

  // first matching position in one table, lowest index wins
  function automatic logic [CodeW:0] tab_find(input tab_arr_t tab,
                                              input logic [CharW-1:0] ch);
    logic [CodeW:0] res;
    res = '0;
    for (int i = TabDepth - 1; i >= 0; i--) begin
      if (SLOT_MASK[i] && ({8'h00, tab[i]} == ch)) begin
        res = {1'b1, CodeW'(i)};
      end
    end
    return res;
  endfunction

  function automatic lkup_t ita2_lookup(input logic [CharW-1:0] ch);
    lkup_t          r;
    logic [CodeW:0] fl;
    logic [CodeW:0] ff;
    fl = tab_find(LETTERS_TAB, ch);
    ff = tab_find(FIGURES_TAB, ch);
    r  = '0;
    if (ch <= MAX_SEVEN_BIT) begin
      if (fl[CodeW]) begin
        r.hit       = 1'b1;
        r.is_letter = 1'b1;
        r.pos       = fl[CodeW-1:0];
        r.direct    = (fl[CodeW-1:0] == POS_LF) || (fl[CodeW-1:0] == POS_CR) ||
                      (fl[CodeW-1:0] == POS_SPACE);
      end else if (ff[CodeW]) begin
        r.hit = 1'b1;
        r.pos = ff[CodeW-1:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/text_to_ita2_encoder.sv */
// top level: character to ita2 symbol encoder with letters/figures shift tracking
`default_nettype none

// usage
//   in channel: one beat carries a 16-bit character code and an end-of-text flag
//   out channel: one beat carries a 5-bit ita2 symbol and last_of_run
//   a character gives zero, one or two out beats; a shift symbol (0x1F letters,
//   0x1B figures) goes ahead of the character when the shift must change, with
//   last_of_run low; the character symbol always has last_of_run high
//   codes above 0x7f and characters in neither table give no out beat
//   an accepted beat is held in the input register, and its first symbol goes
//   to the output register once that register is free
//   throughput: one character per cycle while out does not stall and no shift
//   is needed; a character that needs a shift holds the input register until
//   both its symbols have gone out through the single output register
//   stall on out: the output register holds its beat; the input register still
//   takes one more beat if empty, then in_stall rises until the output drains
//   reset: synchronous, active low; both registers empty, shift state letters
//   end_of_text returns the shift state to letters once its character retires

module text_to_ita2_encoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire ita2e_pkg::in_beat_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      ita2e_pkg::out_beat_t out_data
);

  // input register
  logic                 s1_valid_r, s1_valid_nxt;
  ita2e_pkg::in_beat_t  s1_data_r;
  // output register
  logic                 out_valid_r, out_valid_nxt;
  ita2e_pkg::out_beat_t out_data_r, out_data_nxt;
  // shift state, 1 = figures
  logic                 figures_mode_r, figures_mode_nxt;

  ita2e_pkg::lkup_t lk;
  logic in_accept;
  logic out_free;
  logic need_shift;
  logic emit;
  logic s1_done;

  assign lk = ita2e_pkg::ita2_lookup(s1_data_r.char_code);

  // shift symbol needed when the table of the character is not the current one
  assign need_shift = lk.hit && !lk.direct && (lk.is_letter ? figures_mode_r : !figures_mode_r);

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = s1_valid_r && lk.hit && out_free;
  // item leaves the input register once its character symbol is out, or at once
  // when it has no symbol
  assign s1_done   = s1_valid_r && (!lk.hit || (out_free && !need_shift));
  assign in_stall  = s1_valid_r && !s1_done;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_free) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      if (need_shift) begin
        out_data_nxt.ita2_code   = lk.is_letter ? ita2e_pkg::SHIFT_LETTERS
                                                : ita2e_pkg::SHIFT_FIGURES;
        out_data_nxt.last_of_run = 1'b0;
      end else begin
        out_data_nxt.ita2_code   = lk.pos;
        out_data_nxt.last_of_run = 1'b1;
      end
    end
  end

  // the shift flips the state as soon as it is sent, so the same item then
  // sees no shift need and sends its character the next free cycle
  always_comb begin
    figures_mode_nxt = figures_mode_r;
    if (emit && need_shift) begin
      figures_mode_nxt = !lk.is_letter;
    end
    if (s1_done && s1_data_r.end_of_text) begin
      figures_mode_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      figures_mode_r <= 1'b0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      figures_mode_r <= figures_mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // a beat that is not the last of its character is always a shift symbol
  a_shift_only_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.last_of_run |->
      out_data_r.ita2_code == ita2e_pkg::SHIFT_LETTERS ||
      out_data_r.ita2_code == ita2e_pkg::SHIFT_FIGURES)
    else $error("non-final beat is not a shift symbol");

  // after a shift goes out the state matches the shift that was sent
  a_mode_follows_shift: assert property (@(posedge clk) disable iff (!rst_n)
    emit && need_shift |=>
      figures_mode_r == (out_data_r.ita2_code == ita2e_pkg::SHIFT_FIGURES))
    else $error("shift state does not follow emitted shift");

  // an item that cannot retire stays in the input register unchanged
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_done |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register lost a pending item");
`endif

endmodule

`default_nettype wire
